[rtl/port_activity_monitor_assert.svh]
// Assertion macros for the port activity monitor.
// Both expect clk and rst_n in scope at the place of use.
`ifndef PORT_ACTIVITY_MONITOR_ASSERT_SVH
`define PORT_ACTIVITY_MONITOR_ASSERT_SVH

// same-cycle implication
`define PAM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("port activity monitor: check failed");

// next-cycle implication
`define PAM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("port activity monitor: check failed");

`endif

[rtl/pam_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pam_pkg;

  localparam int PORT_W      = 16;
  localparam int PORT_COUNT  = 65536;
  localparam int TIME_MAX_W  = 32;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = 2;
  localparam int CMDQ_CNT_W  = 3;

  // input modes
  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // result kinds
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  // verdict codes, also used as the frame error status
  localparam logic [2:0] STATUS_NONE     = 3'd0;
  localparam logic [2:0] VERD_TCP_OK     = 3'd0;
  localparam logic [2:0] VERD_UDP_OK     = 3'd1;
  localparam logic [2:0] VERD_NOT_IPV4   = 3'd2;
  localparam logic [2:0] VERD_BAD_IP_HDR = 3'd3;
  localparam logic [2:0] VERD_BAD_L4_HDR = 3'd4;
  localparam logic [2:0] VERD_NO_SYN     = 3'd5;
  localparam logic [2:0] VERD_OTHER      = 3'd6;
  localparam logic [2:0] VERD_TRUNC      = 3'd7;

  // configuration register indexes
  localparam logic CFG_DECAY = 1'b0;
  localparam logic CFG_FULL  = 1'b1;

  localparam logic [7:0] DECAY_RESET = 8'd1;
  localparam logic [7:0] FULL_RESET  = 8'd255;

  // header byte positions
  localparam logic [6:0] POS_ETH_HI    = 7'd12;
  localparam logic [6:0] POS_ETH_LO    = 7'd13;
  localparam logic [6:0] POS_IHL       = 7'd14;
  localparam logic [6:0] POS_PROTO     = 7'd23;
  localparam logic [6:0] POS_SRC_FIRST = 7'd26;
  localparam logic [6:0] POS_SRC_LAST  = 7'd29;
  localparam logic [6:0] POS_L4_MIN    = 7'd30;
  localparam logic [6:0] POS_MAX       = 7'd127;

  // offsets inside the L4 header
  localparam logic [7:0] L4_PORT_HI    = 8'd2;
  localparam logic [7:0] L4_PORT_LO    = 8'd3;
  localparam logic [7:0] L4_UDP_LEN_HI = 8'd4;
  localparam logic [7:0] L4_UDP_LEN_LO = 8'd5;
  localparam logic [7:0] L4_TCP_OFF    = 8'd12;
  localparam logic [7:0] L4_TCP_FLAGS  = 8'd13;

  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0]  TCP_NEED       = 8'd13;
  localparam logic [7:0]  UDP_NEED       = 8'd5;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [3:0]  MIN_TCP_OFF    = 4'd5;
  localparam logic [7:0]  MIN_UDP_LEN    = 8'd8;
  localparam int          TCP_SYN_BIT    = 1;

  typedef struct packed {
    logic [7:0] decay;
    logic [7:0] full;
  } cfg_t;

  typedef struct packed {
    logic                  is_query;
    logic [PORT_W-1:0]     port;
    logic [2:0]            verdict;
    logic [31:0]           src;
    logic [TIME_MAX_W-1:0] tick;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_CALC
  } bk_state_t;

endpackage

`default_nettype wire

[rtl/pam_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pam_front #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_mode,
  input  wire logic [7:0]                in_frame_byte,
  input  wire logic                      in_frame_end,
  input  wire logic [pam_pkg::PORT_W-1:0] in_query_port,
  input  wire logic                      clear_busy,
  input  wire logic                      q_ready,
  output logic                           q_push,
  output pam_pkg::cmd_t                  q_data
);

  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic [6:0]           pos_r, pos_nxt;
  logic [15:0]          port_r, port_nxt;
  logic [31:0]          src_r, src_nxt;
  logic [7:0]           proto_r, proto_nxt;
  logic [3:0]           ihl_r, ihl_nxt;
  logic                 udp_hi_r, udp_hi_nxt;
  logic [2:0]           status_r, status_nxt;

  logic [15:0] port_p;
  logic [31:0] src_p;
  logic [7:0]  proto_p;
  logic [3:0]  ihl_p;
  logic        udp_hi_p;
  logic [2:0]  status_p;
  logic [7:0]  l4_r, l4_p, rel, need;
  logic [2:0]  verdict_c;
  logic        accept;
  logic [7:0]  b;

  assign b        = in_frame_byte;
  assign in_ready = q_ready && !clear_busy;
  assign accept   = in_valid && in_ready;
  assign l4_r     = pam_pkg::ETH_HDR_LEN + {2'b00, ihl_r, 2'b00};
  assign rel      = {1'b0, pos_r} - l4_r;

  // parse the current byte
  always_comb begin
    port_p   = port_r;
    src_p    = src_r;
    proto_p  = proto_r;
    ihl_p    = ihl_r;
    udp_hi_p = udp_hi_r;
    status_p = status_r;
    if (status_r == pam_pkg::STATUS_NONE) begin
      if (pos_r == pam_pkg::POS_ETH_HI) begin
        port_p = {b, 8'h00};
      end else if (pos_r == pam_pkg::POS_ETH_LO) begin
        if ({port_r[15:8], b} != pam_pkg::ETHERTYPE_IPV4) begin
          status_p = pam_pkg::VERD_NOT_IPV4;
        end
        port_p = 16'h0000;
      end else if (pos_r == pam_pkg::POS_IHL) begin
        ihl_p = b[3:0];
        if (b[3:0] < pam_pkg::MIN_IHL) begin
          status_p = pam_pkg::VERD_BAD_IP_HDR;
        end
      end else if (pos_r == pam_pkg::POS_PROTO) begin
        proto_p = b;
        if (b != pam_pkg::PROTO_TCP && b != pam_pkg::PROTO_UDP) begin
          status_p = pam_pkg::VERD_OTHER;
        end
      end else if (pos_r >= pam_pkg::POS_SRC_FIRST && pos_r <= pam_pkg::POS_SRC_LAST) begin
        src_p = {src_r[23:0], b};
      end else if (pos_r >= pam_pkg::POS_L4_MIN && {1'b0, pos_r} >= l4_r) begin
        if (rel == pam_pkg::L4_PORT_HI) begin
          port_p = {b, 8'h00};
        end else if (rel == pam_pkg::L4_PORT_LO) begin
          port_p = port_r | {8'h00, b};
        end else if (proto_r == pam_pkg::PROTO_TCP) begin
          if (rel == pam_pkg::L4_TCP_OFF && b[7:4] < pam_pkg::MIN_TCP_OFF) begin
            status_p = pam_pkg::VERD_BAD_L4_HDR;
          end else if (rel == pam_pkg::L4_TCP_FLAGS && !b[pam_pkg::TCP_SYN_BIT]) begin
            status_p = pam_pkg::VERD_NO_SYN;
          end
        end else begin
          if (rel == pam_pkg::L4_UDP_LEN_HI) begin
            udp_hi_p = (b != 8'h00);
          end else if (rel == pam_pkg::L4_UDP_LEN_LO && !udp_hi_r &&
                       b < pam_pkg::MIN_UDP_LEN) begin
            status_p = pam_pkg::VERD_BAD_L4_HDR;
          end
        end
      end
    end
  end

  // verdict at the last byte
  assign l4_p = pam_pkg::ETH_HDR_LEN + {2'b00, ihl_p, 2'b00};
  assign need = l4_p + ((proto_p == pam_pkg::PROTO_TCP) ? pam_pkg::TCP_NEED
                                                        : pam_pkg::UDP_NEED);

  always_comb begin
    if (status_p != pam_pkg::STATUS_NONE) begin
      verdict_c = status_p;
    end else if (pos_r < pam_pkg::POS_PROTO || {1'b0, pos_r} < need) begin
      verdict_c = pam_pkg::VERD_TRUNC;
    end else if (proto_p == pam_pkg::PROTO_TCP) begin
      verdict_c = pam_pkg::VERD_TCP_OK;
    end else begin
      verdict_c = pam_pkg::VERD_UDP_OK;
    end
  end

  always_comb begin
    tick_nxt   = tick_r;
    pos_nxt    = pos_r;
    port_nxt   = port_r;
    src_nxt    = src_r;
    proto_nxt  = proto_r;
    ihl_nxt    = ihl_r;
    udp_hi_nxt = udp_hi_r;
    status_nxt = status_r;
    if (accept) begin
      case (in_mode)
        pam_pkg::MODE_BYTE: begin
          if (in_frame_end) begin
            pos_nxt    = 7'd0;
            port_nxt   = 16'h0000;
            src_nxt    = 32'h0;
            proto_nxt  = 8'h00;
            ihl_nxt    = 4'h0;
            udp_hi_nxt = 1'b0;
            status_nxt = pam_pkg::STATUS_NONE;
          end else begin
            pos_nxt    = (pos_r == pam_pkg::POS_MAX) ? pos_r : pos_r + 7'd1;
            port_nxt   = port_p;
            src_nxt    = src_p;
            proto_nxt  = proto_p;
            ihl_nxt    = ihl_p;
            udp_hi_nxt = udp_hi_p;
            status_nxt = status_p;
          end
        end
        pam_pkg::MODE_TICK: begin
          tick_nxt = tick_r + TIME_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      pos_r    <= '0;
      port_r   <= '0;
      src_r    <= '0;
      proto_r  <= '0;
      ihl_r    <= '0;
      udp_hi_r <= 1'b0;
      status_r <= pam_pkg::STATUS_NONE;
    end else begin
      tick_r   <= tick_nxt;
      pos_r    <= pos_nxt;
      port_r   <= port_nxt;
      src_r    <= src_nxt;
      proto_r  <= proto_nxt;
      ihl_r    <= ihl_nxt;
      udp_hi_r <= udp_hi_nxt;
      status_r <= status_nxt;
    end
  end

  assign q_push = accept && ((in_mode == pam_pkg::MODE_BYTE && in_frame_end) ||
                             in_mode == pam_pkg::MODE_QUERY);

  always_comb begin
    q_data.is_query = (in_mode == pam_pkg::MODE_QUERY);
    q_data.port     = q_data.is_query ? in_query_port : port_p;
    q_data.verdict  = q_data.is_query ? pam_pkg::VERD_TCP_OK : verdict_c;
    q_data.src      = src_p;
    q_data.tick     = pam_pkg::TIME_MAX_W'(tick_r);
  end

endmodule

`default_nettype wire

[rtl/pam_cmdq.sv]
`timescale 1ns / 1ps
`default_nettype none

module pam_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pam_pkg::cmd_t push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               pop_valid,
  output pam_pkg::cmd_t      pop_data
);

  pam_pkg::cmd_t                  slot_r [pam_pkg::CMDQ_DEPTH];
  logic [pam_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pam_pkg::CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pam_pkg::CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign push_ready = (cnt_r != pam_pkg::CMDQ_CNT_W'(pam_pkg::CMDQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/pam_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pam_back #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pam_pkg::cfg_t              cfg,
  input  wire logic                       q_valid,
  input  wire pam_pkg::cmd_t              q_data,
  output logic                            q_pop,
  output logic                            clear_busy,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic                            out_kind,
  output logic [pam_pkg::PORT_W-1:0]      out_port,
  output logic [2:0]                      out_verdict,
  output logic [7:0]                      out_intensity,
  output logic [31:0]                     out_source_address,
  output logic                            out_was_tcp,
  output logic                            out_ever_seen
);

  localparam int ENTRY_W = TIME_BITS + 34;
  localparam int LOSS_W  = TIME_BITS + 8;
  localparam int SRC_LO  = TIME_BITS;
  localparam int TCP_BIT = TIME_BITS + 32;
  localparam int SEEN_BIT = TIME_BITS + 33;

  pam_pkg::bk_state_t state_r, state_nxt;

  logic [ENTRY_W-1:0]          port_tbl [pam_pkg::PORT_COUNT];
  logic [ENTRY_W-1:0]          rd_data_r;
  logic                        tbl_we, tbl_re;
  logic [pam_pkg::PORT_W-1:0]  tbl_waddr;
  logic [ENTRY_W-1:0]          tbl_wdata;

  logic [pam_pkg::PORT_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [pam_pkg::PORT_W-1:0]  qport_r, qport_nxt;
  logic [TIME_BITS-1:0]        now_r, now_nxt;
  logic [LOSS_W-1:0]           loss_r, loss_nxt;
  logic                        seen_r, seen_nxt;
  logic                        tcp_r, tcp_nxt;
  logic [31:0]                 src_r, src_nxt;
  logic [TIME_BITS-1:0]        age;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [15:0] out_port_r, out_port_nxt;
  logic [2:0]  out_verdict_r, out_verdict_nxt;
  logic [7:0]  out_int_r, out_int_nxt;
  logic [31:0] out_src_r, out_src_nxt;
  logic        out_tcp_r, out_tcp_nxt;
  logic        out_seen_r, out_seen_nxt;

  logic out_free, frame_ok;

  assign out_free   = !out_valid_r || out_ready;
  assign clear_busy = (state_r == pam_pkg::BK_CLEAR);
  assign q_pop      = (state_r == pam_pkg::BK_IDLE) && q_valid && out_free;
  assign frame_ok   = (q_data.verdict == pam_pkg::VERD_TCP_OK) ||
                      (q_data.verdict == pam_pkg::VERD_UDP_OK);
  assign age        = now_r - rd_data_r[TIME_BITS-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pam_pkg::BK_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = pam_pkg::BK_IDLE;
        end
      end
      pam_pkg::BK_IDLE: begin
        if (q_pop && q_data.is_query) begin
          state_nxt = pam_pkg::BK_READ;
        end
      end
      pam_pkg::BK_READ: state_nxt = pam_pkg::BK_CALC;
      pam_pkg::BK_CALC: state_nxt = pam_pkg::BK_IDLE;
      default:          state_nxt = pam_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    tbl_waddr    = q_data.port;
    tbl_wdata    = {1'b1, q_data.verdict == pam_pkg::VERD_TCP_OK, q_data.src,
                    q_data.tick[TIME_BITS-1:0]};
    clr_addr_nxt = clr_addr_r;
    qport_nxt    = qport_r;
    now_nxt      = now_r;
    loss_nxt     = loss_r;
    seen_nxt     = seen_r;
    tcp_nxt      = tcp_r;
    src_nxt      = src_r;

    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_port_nxt    = out_port_r;
    out_verdict_nxt = out_verdict_r;
    out_int_nxt     = out_int_r;
    out_src_nxt     = out_src_r;
    out_tcp_nxt     = out_tcp_r;
    out_seen_nxt    = out_seen_r;

    case (state_r)
      pam_pkg::BK_CLEAR: begin
        tbl_we       = 1'b1;
        tbl_waddr    = clr_addr_r;
        tbl_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      pam_pkg::BK_IDLE: begin
        if (q_pop) begin
          if (q_data.is_query) begin
            tbl_re    = 1'b1;
            qport_nxt = q_data.port;
            now_nxt   = q_data.tick[TIME_BITS-1:0];
          end else begin
            tbl_we          = frame_ok;
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = pam_pkg::KIND_VERDICT;
            out_port_nxt    = q_data.port;
            out_verdict_nxt = q_data.verdict;
            out_int_nxt     = 8'd0;
            out_src_nxt     = 32'h0;
            out_tcp_nxt     = 1'b0;
            out_seen_nxt    = 1'b0;
          end
        end
      end
      pam_pkg::BK_READ: begin
        loss_nxt = {{TIME_BITS{1'b0}}, cfg.decay} * {8'h00, age};
        seen_nxt = rd_data_r[SEEN_BIT];
        tcp_nxt  = rd_data_r[TCP_BIT];
        src_nxt  = rd_data_r[SRC_LO +: 32];
      end
      pam_pkg::BK_CALC: begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = pam_pkg::KIND_QUERY;
        out_port_nxt    = qport_r;
        out_verdict_nxt = pam_pkg::VERD_TCP_OK;
        out_seen_nxt    = seen_r;
        out_tcp_nxt     = seen_r && tcp_r;
        out_src_nxt     = seen_r ? src_r : 32'h0;
        if (!seen_r || loss_r >= LOSS_W'(cfg.full)) begin
          out_int_nxt = 8'd0;
        end else begin
          out_int_nxt = cfg.full - loss_r[7:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      port_tbl[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      rd_data_r <= port_tbl[q_data.port];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pam_pkg::BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qport_r       <= qport_nxt;
    now_r         <= now_nxt;
    loss_r        <= loss_nxt;
    seen_r        <= seen_nxt;
    tcp_r         <= tcp_nxt;
    src_r         <= src_nxt;
    out_kind_r    <= out_kind_nxt;
    out_port_r    <= out_port_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_int_r     <= out_int_nxt;
    out_src_r     <= out_src_nxt;
    out_tcp_r     <= out_tcp_nxt;
    out_seen_r    <= out_seen_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_port           = out_port_r;
  assign out_verdict        = out_verdict_r;
  assign out_intensity      = out_int_r;
  assign out_source_address = out_src_r;
  assign out_was_tcp        = out_tcp_r;
  assign out_ever_seen      = out_seen_r;

endmodule

`default_nettype wire

[rtl/port_activity_monitor.sv]
// Channel  Direction  Handshake              Word
// in_      input      in_valid / in_ready    mode, frame byte, frame end, query port
// out_     output     out_valid / out_ready  verdict or query answer
// cfg_     input      cfg_we                 register index and 8-bit data
//
// Frame bytes and ticks are taken one per cycle unless the queue is full or clearing runs;
// a frame end or query enters a 4-word queue. A frame verdict goes straight to the output
// register. A query steps through table read, multiply and compare; nothing is popped meanwhile.
// After reset a clearing pass writes all 65536 table entries, one per cycle; in_ready
// stays low until the pass is done. Configuration writes are taken throughout.
// A stalled output holds its word while the queue keeps taking input until full.
`timescale 1ns / 1ps
`default_nettype none
`include "port_activity_monitor_assert.svh"

module port_activity_monitor #(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_frame_end,
  input  wire logic [15:0] in_query_port,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_port,
  output logic [2:0]       out_verdict,
  output logic [7:0]       out_intensity,
  output logic [31:0]      out_source_address,
  output logic             out_was_tcp,
  output logic             out_ever_seen,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  pam_pkg::cfg_t cfg_r, cfg_nxt;
  pam_pkg::cmd_t push_data, q_data;
  logic          q_push, q_ready, q_valid, q_pop, clear_busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pam_pkg::CFG_DECAY: cfg_nxt.decay = cfg_wdata;
        pam_pkg::CFG_FULL:  cfg_nxt.full  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay <= pam_pkg::DECAY_RESET;
      cfg_r.full  <= pam_pkg::FULL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pam_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_frame_byte (in_frame_byte),
    .in_frame_end  (in_frame_end),
    .in_query_port (in_query_port),
    .clear_busy    (clear_busy),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  pam_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_data),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  pam_back #(
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .clear_busy         (clear_busy),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_port           (out_port),
    .out_verdict        (out_verdict),
    .out_intensity      (out_intensity),
    .out_source_address (out_source_address),
    .out_was_tcp        (out_was_tcp),
    .out_ever_seen      (out_ever_seen)
  );

  `PAM_ASSERT_IMP(a_no_input_while_clearing, clear_busy, !in_ready)
  `PAM_ASSERT_IMP(a_verdict_clean, out_valid && !out_kind, out_intensity == 8'd0 && !out_ever_seen && !out_was_tcp && out_source_address == 32'h0)
  `PAM_ASSERT_IMP(a_unseen_clean, out_valid && out_kind && !out_ever_seen, out_intensity == 8'd0 && !out_was_tcp && out_source_address == 32'h0)
  `PAM_ASSERT_NXT(a_query_slot_free, q_pop && q_data.is_query, !out_valid)

endmodule

`default_nettype wire
